// ----- rtl/bbr_pkg.sv -----
`default_nettype none

package bbr_pkg;

  localparam int CH_W        = 8;
  localparam int SUM_W       = 12;
  localparam int COORD_W     = 10;
  localparam int CFG_W       = 11;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;

  // floor(s * 7282 / 2^16) == floor(s / 9) for every s up to 9 * 255
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // one line store entry: pixel two rows up and one row up
  typedef struct packed {
    pix_t up;
    pix_t mid;
  } store_t;

  // one window column, oldest row first
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // in-frame flags of the window's border rows and columns
  typedef struct packed {
    logic c0;
    logic c2;
    logic r0;
    logic r2;
  } mask_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line;
    logic               eof;
  } meta_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

endpackage

`default_nettype wire

// ----- rtl/box_blur_3x3_rgb_core.sv -----
`default_nettype none

// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  tdata: red, green, blue; tuser: op (1 = flush)
// out_      out  out_tvalid/out_tready tdata: red, green, blue, column, line; tlast: eof
// cfg_      in   cfg_we               cfg_addr: register index, cfg_wdata: value
//
// one transfer per clock while the skid register is empty; out_tvalid is registered behind
// the transfer that completes a window, which lags the blurred pixel by width + 1 items
// both line stores share one memory, read on accept and written back at the next advance;
// stale entries are read only in the first rows after an end of frame, as masked neighbors
// rst_n is synchronous; the line store is not cleared, the window is zeroed
// in_tready drops only while the output skid register is full
module box_blur_3x3_rgb_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  wire logic        in_tuser,   // op

  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_red [7:0], out_green [15:8], out_blue [23:16], column [33:24],
  // line [43:34], zero [47:44]
  output logic [47:0]      out_tdata,
  output logic             out_tlast,  // end_of_frame

  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [10:0] cfg_wdata
);
  import bbr_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CMPW = ((CW > RW) ? CW : RW) > CFG_W ? ((CW > RW) ? CW : RW) + 1 : CFG_W + 1;
  localparam int RST_W = (800 > MAX_WIDTH) ? MAX_WIDTH : 800;
  localparam int RST_H = (600 > MAX_HEIGHT) ? MAX_HEIGHT : 600;

  // clamp to [2, hi] and keep the value minus one
  function automatic logic [CFG_W-1:0] clamp_m1(input logic [CFG_W-1:0] v, input int hi);
    if (v < CFG_W'(2)) begin
      return CFG_W'(1);
    end else if (int'(v) > hi) begin
      return CFG_W'(hi - 1);
    end else begin
      return v - CFG_W'(1);
    end
  endfunction

  // config
  logic [CFG_W-1:0] w_m1_r;
  logic [CFG_W-1:0] h_m1_r;

  // frame counters; in_row saturates at two, enough to tell the start-up lag
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [1:0]    in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;

  logic  adv;
  logic  in_acc;
  logic  emit;
  logic  col_last;
  logic  ocol_last;
  logic  orow_last;
  logic  eof;
  pix_t  in_pix;
  mask_t mask_in;
  meta_t meta_in;

  // stage 1: line store read data is valid
  logic          v1_r;
  logic          emit1_r;
  logic [CW-1:0] addr1_r;
  pix_t          data1_r;
  mask_t         mask1_r;
  meta_t         meta1_r;

  // stage 2: window holds the item's neighbourhood
  logic  v2_r;
  mask_t mask2_r;
  meta_t meta2_r;

  // stage 3: sums registered
  logic  v3_r;
  meta_t meta3_r;

  store_t rd_data;
  store_t wr_data;
  col_t   new_col;
  sum_t   sum;
  pix_t   out_pix;
  meta_t  out_meta;
  logic   wr_en;

  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  assign in_pix.red   = in_tuser ? '0 : in_tdata[7:0];
  assign in_pix.green = in_tuser ? '0 : in_tdata[15:8];
  assign in_pix.blue  = in_tuser ? '0 : in_tdata[23:16];

  assign col_last  = CMPW'(in_col_r) == CMPW'(w_m1_r);
  assign ocol_last = CMPW'(out_col_r) == CMPW'(w_m1_r);
  assign orow_last = CMPW'(out_row_r) == CMPW'(h_m1_r);
  assign eof       = ocol_last && orow_last;
  // first result once the center pixel's right neighbour on the next row arrived
  assign emit      = (in_row_r == 2'd2) || (in_row_r == 2'd1 && in_col_r != '0);

  assign mask_in.c0     = out_col_r != '0;
  assign mask_in.c2     = !ocol_last;
  assign mask_in.r0     = out_row_r != '0;
  assign mask_in.r2     = !orow_last;
  assign meta_in.column = COORD_W'(out_col_r);
  assign meta_in.line   = COORD_W'(out_row_r);
  assign meta_in.eof    = eof;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (in_acc) begin
      if (col_last) begin
        in_col_nxt = '0;
        if (in_row_r != 2'd2) begin
          in_row_nxt = in_row_r + 2'd1;
        end
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (emit) begin
        if (eof) begin
          // frame done, next transfer starts a new frame
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (ocol_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + RW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r    <= CFG_W'(RST_W - 1);
      h_m1_r    <= CFG_W'(RST_H - 1);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == REG_FRAME_WIDTH) begin
        w_m1_r <= clamp_m1(cfg_wdata, MAX_WIDTH);
      end
      if (cfg_we && cfg_addr == REG_FRAME_HEIGHT) begin
        h_m1_r <= clamp_m1(cfg_wdata, MAX_HEIGHT);
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (adv) begin
        v1_r <= in_acc;
        v2_r <= v1_r && emit1_r;
        v3_r <= v2_r;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (in_acc) begin
      emit1_r <= emit;
      addr1_r <= in_col_r;
      data1_r <= in_pix;
      mask1_r <= mask_in;
      meta1_r <= meta_in;
    end
    if (adv) begin
      mask2_r <= mask1_r;
      meta2_r <= meta1_r;
      meta3_r <= meta2_r;
    end
  end

  // write back: upper takes the old middle, middle takes the new pixel
  assign wr_en       = v1_r && adv;
  assign wr_data.up  = rd_data.mid;
  assign wr_data.mid = data1_r;
  assign new_col.top = rd_data.up;
  assign new_col.mid = rd_data.mid;
  assign new_col.bot = data1_r;

  bbr_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_col_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr1_r),
    .wr_data (wr_data)
  );

  bbr_window_sum u_window_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .shift   (wr_en),
    .new_col (new_col),
    .mask    (mask2_r),
    .sum     (sum)
  );

  bbr_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (v3_r),
    .res_sum   (sum),
    .res_meta  (meta3_r),
    .adv       (adv),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix),
    .out_meta  (out_meta)
  );

  assign out_tdata = {4'b0000, out_meta.line, out_meta.column,
                      out_pix.blue, out_pix.green, out_pix.red};
  assign out_tlast = out_meta.eof;

endmodule

`default_nettype wire

// ----- rtl/bbr_line_store.sv -----
`default_nettype none

module bbr_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output bbr_pkg::store_t      rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire bbr_pkg::store_t wr_data
);
  import bbr_pkg::*;

  store_t mem [DEPTH];
  store_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/bbr_window_sum.sv -----
`default_nettype none

module bbr_window_sum (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           shift,
  input  wire bbr_pkg::col_t  new_col,
  input  wire bbr_pkg::mask_t mask,
  output bbr_pkg::sum_t       sum
);
  import bbr_pkg::*;

  col_t win_r [3];
  sum_t sum_r;
  sum_t sum_nxt;

  // window shifts left, newest column on the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r[0] <= '0;
      win_r[1] <= '0;
      win_r[2] <= '0;
    end else if (shift) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= new_col;
    end
  end

  always_comb begin
    logic col_en;
    sum_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      col_en = (k == 0) ? mask.c0 : ((k == 2) ? mask.c2 : 1'b1);
      if (col_en) begin
        if (mask.r0) begin
          sum_nxt.red   = sum_nxt.red   + SUM_W'(win_r[k].top.red);
          sum_nxt.green = sum_nxt.green + SUM_W'(win_r[k].top.green);
          sum_nxt.blue  = sum_nxt.blue  + SUM_W'(win_r[k].top.blue);
        end
        sum_nxt.red   = sum_nxt.red   + SUM_W'(win_r[k].mid.red);
        sum_nxt.green = sum_nxt.green + SUM_W'(win_r[k].mid.green);
        sum_nxt.blue  = sum_nxt.blue  + SUM_W'(win_r[k].mid.blue);
        if (mask.r2) begin
          sum_nxt.red   = sum_nxt.red   + SUM_W'(win_r[k].bot.red);
          sum_nxt.green = sum_nxt.green + SUM_W'(win_r[k].bot.green);
          sum_nxt.blue  = sum_nxt.blue  + SUM_W'(win_r[k].bot.blue);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

`default_nettype wire

// ----- rtl/bbr_out_stage.sv -----
`default_nettype none

module bbr_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  input  wire bbr_pkg::sum_t  res_sum,
  input  wire bbr_pkg::meta_t res_meta,
  output logic               adv,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bbr_pkg::pix_t      out_pix,
  output bbr_pkg::meta_t     out_meta
);
  import bbr_pkg::*;

  typedef struct packed {
    pix_t  pix;
    meta_t meta;
  } res_t;

  res_t res;
  res_t out_r;
  res_t skid_r;
  logic out_v_r;
  logic skid_v_r;

  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+RECIP_W-1:0] prod;
    prod = SUM_W'(s) * RECIP9;
    return prod[RECIP_SHIFT +: CH_W];
  endfunction

  always_comb begin
    res.pix.red   = div9(res_sum.red);
    res.pix.green = div9(res_sum.green);
    res.pix.blue  = div9(res_sum.blue);
    res.meta      = res_meta;
  end

  assign adv = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_v_r && !out_ready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (res_valid) begin
      if (out_v_r && !out_ready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_pix   = out_r.pix;
  assign out_meta  = out_r.meta;

endmodule

`default_nettype wire
